// File: hdl/battery_percent_stabilizer_macros.svh
// ============================================================================
// Battery percent stabilizer assertion macros
// Shared concurrent assertion forms for the checker, clocked on aclk.
// ============================================================================
`ifndef BATTERY_PERCENT_STABILIZER_MACROS_SVH
`define BATTERY_PERCENT_STABILIZER_MACROS_SVH

// Property that is checked only while the block is out of reset.
`define BPS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("bps assertion failed");

// Property that is also checked across reset.
`define BPS_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("bps reset assertion failed");

`endif

// File: hdl/bps_pkg.sv
// ============================================================================
// Battery percent stabilizer package
// Field widths, register indexes and reset values shared by the block.
// ============================================================================
`default_nettype none

package bps_pkg;

    localparam int MvW  = 13;
    localparam int PctW = 7;
    localparam int IdxW = 3;

    typedef logic [MvW-1:0]  mv_t;
    typedef logic [PctW-1:0] pct_t;

    localparam pct_t PctFull = 7'd100;

    // Configuration register indexes.
    typedef enum logic [IdxW-1:0] {
        REG_MID_CHARGE_MV    = 3'd0,
        REG_CHARGE_RISE_MV   = 3'd1,
        REG_CHARGE_FALL_MV   = 3'd2,
        REG_CRITICAL_MV      = 3'd3,
        REG_CRITICAL_PERCENT = 3'd4,
        REG_SLEW_STEP        = 3'd5
    } cfg_idx_t;

    // Reset values of the configuration registers and the state.
    localparam mv_t  RstMidChargeMv   = 13'd3900;
    localparam mv_t  RstChargeRiseMv  = 13'd100;
    localparam mv_t  RstChargeFallMv  = 13'd100;
    localparam mv_t  RstCriticalMv    = 13'd3300;
    localparam pct_t RstCriticalPct   = 7'd5;
    localparam pct_t RstSlewStep      = 7'd1;
    localparam pct_t RstStablePercent = 7'd100;
    localparam mv_t  RstStableVoltage = 13'd4200;

endpackage

`default_nettype wire

// File: hdl/battery_percent_stabilizer.sv
// ============================================================================
// Battery percent stabilizer
// Turns raw battery samples into a charge percent that does not jump when a
// charger is connected or removed, and tracks a charging flag.
// ============================================================================
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_voltage_mv, s_raw_percent,
//                                           s_cold_start, s_bypass
//   m_        out        m_valid/m_ready    m_percent, m_charging
//   cfg_      in         cfg_we             cfg_addr, cfg_wdata
//
// One item per cycle while the result is not stalled; each item passes from
// acceptance through the input register and then the state update that
// loads the result register. The state update is a single compare-and-select
// step, so back-to-back items see each other's state without bubbles.
// Reset (aresetn low, synchronous) empties both registers and restores the
// configuration and state reset values. A stalled result stays put and holds a full input register.
//
`default_nettype none

module battery_percent_stabilizer import bps_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // Input items.
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [MvW-1:0]  s_voltage_mv,
    input  wire logic [PctW-1:0] s_raw_percent,
    input  wire logic            s_cold_start,
    input  wire logic            s_bypass,
    // Result items.
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [PctW-1:0]      m_percent,
    output logic                 m_charging,
    // Configuration writes.
    input  wire logic            cfg_we,
    input  wire logic [IdxW-1:0] cfg_addr,
    input  wire logic [MvW-1:0]  cfg_wdata
);

    // Configuration registers.
    mv_t  mid_charge_mv_reg;
    mv_t  charge_rise_mv_reg;
    mv_t  charge_fall_mv_reg;
    mv_t  critical_mv_reg;
    pct_t critical_percent_reg;
    pct_t slew_step_reg;

    // Stabilizer state.
    logic charging_reg, charging_next;
    pct_t stable_pct_reg, stable_pct_next;
    mv_t  stable_mv_reg, stable_mv_next;
    logic seeded_reg, seeded_next;

    // Input register.
    logic in_valid_reg;
    mv_t  in_mv_reg;
    pct_t in_raw_reg;
    logic in_cold_reg;
    logic in_bypass_reg;

    // Result register.
    logic out_valid_reg;
    pct_t out_pct_reg, out_pct_next;

    logic advance;
    logic s_accept;

    // An item moves to the result register whenever that register is free or
    // being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign m_valid    = out_valid_reg;
    assign m_percent  = out_pct_reg;
    assign m_charging = charging_reg;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_charge_mv_reg    <= RstMidChargeMv;
            charge_rise_mv_reg   <= RstChargeRiseMv;
            charge_fall_mv_reg   <= RstChargeFallMv;
            critical_mv_reg      <= RstCriticalMv;
            critical_percent_reg <= RstCriticalPct;
            slew_step_reg        <= RstSlewStep;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MID_CHARGE_MV:    mid_charge_mv_reg    <= cfg_wdata;
                REG_CHARGE_RISE_MV:   charge_rise_mv_reg   <= cfg_wdata;
                REG_CHARGE_FALL_MV:   charge_fall_mv_reg   <= cfg_wdata;
                REG_CRITICAL_MV:      critical_mv_reg      <= cfg_wdata;
                REG_CRITICAL_PERCENT: critical_percent_reg <= cfg_wdata[PctW-1:0];
                REG_SLEW_STEP:        slew_step_reg        <= cfg_wdata[PctW-1:0];
                default: ;
            endcase
        end
    end

    // Input register; the raw percent is clamped to full on entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_accept) begin
            in_mv_reg     <= s_voltage_mv;
            in_raw_reg    <= (s_raw_percent > PctFull) ? PctFull : s_raw_percent;
            in_cold_reg   <= s_cold_start;
            in_bypass_reg <= s_bypass;
        end
    end

    // One stabilizing step on the registered item.
    always_comb begin
        logic [MvW:0]  rise_sum;
        logic [MvW:0]  fall_sum;
        logic [PctW:0] up_sum;
        logic [PctW:0] down_sum;
        logic          chg;

        rise_sum = {1'b0, stable_mv_reg} + {1'b0, charge_rise_mv_reg};
        fall_sum = {1'b0, in_mv_reg} + {1'b0, charge_fall_mv_reg};
        up_sum   = {1'b0, stable_pct_reg} + {1'b0, slew_step_reg};
        down_sum = {1'b0, in_raw_reg} + {1'b0, slew_step_reg};

        // Charger connect and removal detection.
        chg = charging_reg;
        if (!charging_reg && (mid_charge_mv_reg <= in_mv_reg)
                && (rise_sum < {1'b0, in_mv_reg})) begin
            chg = 1'b1;
        end else if (charging_reg && (fall_sum <= {1'b0, stable_mv_reg})) begin
            chg = 1'b0;
        end

        charging_next   = charging_reg;
        stable_pct_next = stable_pct_reg;
        stable_mv_next  = stable_mv_reg;
        seeded_next     = seeded_reg;

        if (in_bypass_reg) begin
            // Bypass loads the raw values and leaves the flags alone.
            stable_pct_next = in_raw_reg;
            stable_mv_next  = in_mv_reg;
        end else begin
            charging_next = chg;
            if (!seeded_reg) begin
                // The first sample seeds the state.
                if (in_cold_reg || chg) begin
                    stable_pct_next = in_raw_reg;
                end else if (in_raw_reg < stable_pct_reg) begin
                    stable_pct_next = in_raw_reg;
                end
                stable_mv_next = in_mv_reg;
                seeded_next    = 1'b1;
            end else if (in_mv_reg < critical_mv_reg) begin
                // Below the critical voltage the percent is capped.
                stable_pct_next = (critical_percent_reg < in_raw_reg) ?
                                  critical_percent_reg : in_raw_reg;
                stable_mv_next  = in_mv_reg;
            end else if (chg && (stable_pct_reg < in_raw_reg)) begin
                // Slew upward while charging; the result never exceeds the raw percent.
                stable_pct_next = (up_sum < {1'b0, in_raw_reg}) ?
                                  up_sum[PctW-1:0] : in_raw_reg;
                stable_mv_next  = in_mv_reg;
            end else if (!chg && (in_raw_reg < stable_pct_reg)) begin
                // Slew downward while discharging.
                stable_pct_next = (down_sum < {1'b0, stable_pct_reg}) ?
                                  (stable_pct_reg - slew_step_reg) : in_raw_reg;
                stable_mv_next  = in_mv_reg;
            end
        end

        out_pct_next = in_bypass_reg ? in_raw_reg : stable_pct_next;
    end

    // State and result register update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            charging_reg   <= 1'b0;
            stable_pct_reg <= RstStablePercent;
            stable_mv_reg  <= RstStableVoltage;
            seeded_reg     <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg  <= 1'b1;
                charging_reg   <= charging_next;
                stable_pct_reg <= stable_pct_next;
                stable_mv_reg  <= stable_mv_next;
                seeded_reg     <= seeded_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            out_pct_reg <= out_pct_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/bps_checker.sv
// ============================================================================
// Battery percent stabilizer checker
// Port-level assertions on the stabilizer, attached by a bind statement.
// ============================================================================
`default_nettype none

`include "battery_percent_stabilizer_macros.svh"

module bps_assertions import bps_pkg::*; (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire logic [PctW-1:0] m_percent,
    input wire logic            m_charging
);

    // No result is offered in the cycle after reset.
    `BPS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid)

    // A stalled result keeps its item.
    `BPS_ASSERT(a_stall_hold,
                m_valid && !m_ready |=> m_valid && $stable(m_percent) && $stable(m_charging))

    // A shown percent never exceeds full charge.
    `BPS_ASSERT(a_percent_range, m_valid |-> m_percent <= PctFull)

    // Input back-pressure only comes from a stalled result.
    `BPS_ASSERT(a_ready_cause, !s_ready |-> m_valid && !m_ready)

endmodule

bind battery_percent_stabilizer bps_assertions u_bps_assertions (.*);

`default_nettype wire
